// ===== hdl/subscribed_keyed_message_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the subscribed keyed message queue
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUBSCRIBED_KEYED_MESSAGE_QUEUE_ASSERT_SVH
`define SUBSCRIBED_KEYED_MESSAGE_QUEUE_ASSERT_SVH

// same-cycle implication
`define SKMQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skmq assertion failed");

// next-cycle implication
`define SKMQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skmq assertion failed");

`endif

// ===== hdl/skmq_pkg.sv =====
// ----------------------------------------------------------------------------
// skmq_pkg
// Shared types and constants for the subscribed keyed message queue.
// ----------------------------------------------------------------------------
package skmq_pkg;

    localparam int MAX_SUBSCRIBERS = 16;
    localparam int QUEUE_DEPTH     = 64;
    localparam int HANDLE_WIDTH    = 32;

    localparam int ID_W    = 64;
    localparam int KEY_W   = 2 * ID_W;
    localparam int HDL_W   = 32;
    localparam int CNT_W   = 7;
    localparam int TYPE_W  = 3;
    localparam int STAT_W  = 2;

    localparam int SUB_AW  = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
    localparam int Q_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int IDX_W   = (SUB_AW > Q_AW) ? SUB_AW : Q_AW;
    localparam int SCAN_W  = IDX_W + 1;
    localparam int QENT_W  = HANDLE_WIDTH + KEY_W;

    typedef enum logic [TYPE_W-1:0] {
        REQ_SUBSCRIBE   = 3'd0,
        REQ_UNSUBSCRIBE = 3'd1,
        REQ_QUERY       = 3'd2,
        REQ_PUSH        = 3'd3,
        REQ_POP         = 3'd4
    } req_type_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_FULL = 2'd2
    } status_t;

endpackage

// ===== hdl/subscribed_keyed_message_queue.sv =====
// ----------------------------------------------------------------------------
// subscribed_keyed_message_queue
// Subscriber set of 128-bit ids plus one ordered message queue with
// keyed pop; one shared 128-bit key comparator walks both stores.
// ----------------------------------------------------------------------------
// Channel   Handshake          Fields
// request   start / busy       req_type, receiver_id_hi, receiver_id_lo,
//                              message_handle
// result    done (1 cycle)     status, popped_handle, queue_count
//
// A request is taken when start is high and busy is low; done pulses once.
// Subscribe, unsubscribe, query, push: one read per subscriber slot through
// the comparator. Pop: scan to the oldest match, then move each later entry
// down one per cycle. Unknown type: never busy. done rises in the same
// cycle that busy falls, or right after the accept for an unknown type.
// Ready at once after reset; the result side cannot stall.
// ----------------------------------------------------------------------------
module subscribed_keyed_message_queue
    import skmq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [TYPE_W-1:0] req_type,
    input  logic [ID_W-1:0]   receiver_id_hi,
    input  logic [ID_W-1:0]   receiver_id_lo,
    input  logic [HDL_W-1:0]  message_handle,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [HDL_W-1:0]  popped_handle,
    output logic [CNT_W-1:0]  queue_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUB_SCAN,
        S_Q_SCAN,
        S_SHIFT
    } state_t;

    state_t                  state_reg, state_next;
    logic [TYPE_W-1:0]       req_reg, req_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [HANDLE_WIDTH-1:0] hdl_reg, hdl_next;
    logic [SCAN_W-1:0]       idx_reg, idx_next;
    logic                    lag_vld_reg, lag_vld_next;
    logic [IDX_W-1:0]        lag_idx_reg, lag_idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    sub_valid_reg [MAX_SUBSCRIBERS];
    logic                    sub_valid_next [MAX_SUBSCRIBERS];
    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [HANDLE_WIDTH-1:0] popped_reg, popped_next;

    logic                    sub_we;
    logic [SUB_AW-1:0]       sub_waddr;
    logic [KEY_W-1:0]        sub_rdata;
    logic                    q_we;
    logic [Q_AW-1:0]         q_waddr;
    logic [QENT_W-1:0]       q_wdata;
    logic [QENT_W-1:0]       q_rdata;

    logic [SCAN_W-1:0]       issue_lim;
    logic                    issue;
    logic [KEY_W-1:0]        cmp_key;
    logic                    key_eq;
    logic                    hit;
    logic                    scan_end;
    logic                    free_found;
    logic [SUB_AW-1:0]       free_slot;

    skmq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_SUBSCRIBERS)
    ) u_sub_ram (
        .clk   (clk),
        .we    (sub_we),
        .waddr (sub_waddr),
        .wdata (key_reg),
        .raddr (idx_reg[SUB_AW-1:0]),
        .rdata (sub_rdata)
    );

    skmq_ram #(
        .WIDTH (QENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_q_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (idx_reg[Q_AW-1:0]),
        .rdata (q_rdata)
    );

    // shared key comparator, fed by whichever store is being walked
    assign issue_lim = (state_reg == S_SUB_SCAN) ? SCAN_W'(MAX_SUBSCRIBERS)
                                                 : SCAN_W'(count_reg);
    assign issue     = (idx_reg < issue_lim);
    assign cmp_key   = (state_reg == S_SUB_SCAN) ? sub_rdata : q_rdata[KEY_W-1:0];
    assign key_eq    = (cmp_key == key_reg);
    assign hit       = lag_vld_reg && key_eq &&
                       ((state_reg == S_Q_SCAN) || sub_valid_reg[lag_idx_reg[SUB_AW-1:0]]);
    assign scan_end  = !issue && !lag_vld_reg;

    // lowest free subscriber slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = MAX_SUBSCRIBERS - 1; i >= 0; i--)
        begin
            if (!sub_valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SUB_AW'(i);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        key_next     = key_reg;
        hdl_next     = hdl_reg;
        idx_next     = idx_reg;
        lag_vld_next = lag_vld_reg;
        lag_idx_next = lag_idx_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        popped_next  = popped_reg;
        for (int i = 0; i < MAX_SUBSCRIBERS; i++)
        begin
            sub_valid_next[i] = sub_valid_reg[i];
        end
        sub_we    = 1'b0;
        sub_waddr = free_slot;
        q_we      = 1'b0;
        q_waddr   = lag_idx_reg[Q_AW-1:0];
        q_wdata   = q_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next     = req_type;
                    key_next     = {receiver_id_hi, receiver_id_lo};
                    hdl_next     = message_handle[HANDLE_WIDTH-1:0];
                    popped_next  = '0;
                    idx_next     = '0;
                    lag_vld_next = 1'b0;
                    case (req_type)
                        REQ_SUBSCRIBE, REQ_UNSUBSCRIBE, REQ_QUERY, REQ_PUSH:
                            state_next = S_SUB_SCAN;
                        REQ_POP:
                            state_next = S_Q_SCAN;
                        default:
                        begin
                            status_next = ST_FAIL;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            S_SUB_SCAN:
            begin
                idx_next     = issue ? idx_reg + SCAN_W'(1) : idx_reg;
                lag_vld_next = issue;
                lag_idx_next = idx_reg[IDX_W-1:0];
                if (hit)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    case (req_reg)
                        REQ_SUBSCRIBE:
                            status_next = ST_FAIL;
                        REQ_UNSUBSCRIBE:
                            sub_valid_next[lag_idx_reg[SUB_AW-1:0]] = 1'b0;
                        REQ_PUSH:
                        begin
                            if (count_reg >= CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                q_we       = 1'b1;
                                q_waddr    = count_reg[Q_AW-1:0];
                                q_wdata    = {hdl_reg, key_reg};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        default:
                            status_next = ST_OK;
                    endcase
                end
                else if (scan_end)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_FAIL;
                    if (req_reg == REQ_SUBSCRIBE)
                    begin
                        if (free_found)
                        begin
                            sub_we                    = 1'b1;
                            sub_valid_next[free_slot] = 1'b1;
                            status_next               = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                end
            end

            S_Q_SCAN:
            begin
                idx_next     = issue ? idx_reg + SCAN_W'(1) : idx_reg;
                lag_vld_next = issue;
                lag_idx_next = idx_reg[IDX_W-1:0];
                if (hit)
                begin
                    // close the gap: read entry k+1 onward, write one below
                    popped_next  = q_rdata[QENT_W-1:KEY_W];
                    idx_next     = SCAN_W'(lag_idx_reg) + SCAN_W'(1);
                    lag_vld_next = 1'b0;
                    state_next   = S_SHIFT;
                end
                else if (scan_end)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_FAIL;
                end
            end

            S_SHIFT:
            begin
                idx_next     = issue ? idx_reg + SCAN_W'(1) : idx_reg;
                lag_vld_next = issue;
                lag_idx_next = IDX_W'(idx_reg - SCAN_W'(1));
                if (lag_vld_reg)
                begin
                    q_we = 1'b1;
                end
                if (scan_end)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lag_vld_reg <= 1'b0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            popped_reg  <= '0;
            idx_reg     <= '0;
            for (int i = 0; i < MAX_SUBSCRIBERS; i++)
            begin
                sub_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            lag_vld_reg <= lag_vld_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            popped_reg  <= popped_next;
            idx_reg     <= idx_next;
            for (int i = 0; i < MAX_SUBSCRIBERS; i++)
            begin
                sub_valid_reg[i] <= sub_valid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        hdl_reg     <= hdl_next;
        lag_idx_reg <= lag_idx_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign popped_handle = HDL_W'(popped_reg);
    assign queue_count   = count_reg;

`include "subscribed_keyed_message_queue_assert.svh"

    `SKMQ_ASSERT_IMP(a_done_not_busy, done_reg, !busy)
    `SKMQ_ASSERT_NXT(a_accept_progress, start && !busy, busy || done_reg)
    `SKMQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `SKMQ_ASSERT_IMP(a_count_on_done, count_reg != $past(count_reg), done_reg)
    `SKMQ_ASSERT_IMP(a_popped_ok, done_reg && (popped_reg != '0), status_reg == ST_OK)

endmodule

// ===== hdl/skmq_ram.sv =====
// ----------------------------------------------------------------------------
// skmq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module skmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
